[hw/rtl/worker_pool_load_balancer_assert.svh]
// Assertion macros for the worker pool load balancer.
// Depends on nothing; included by modules that check their own logic.
`ifndef WORKER_POOL_LOAD_BALANCER_ASSERT_SVH
`define WORKER_POOL_LOAD_BALANCER_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define WPLB_ASSERT_IMP(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
`define WPLB_ASSERT_NXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`else
`define WPLB_ASSERT_IMP(label, clk, rst_n, a, c)
`define WPLB_ASSERT_NXT(label, clk, rst_n, a, c)
`endif
`endif

[hw/rtl/wplb_pkg.sv]
// Types and constants shared by the worker pool load balancer.
// Depends on nothing.
package wplb_pkg;
    localparam logic [2:0] ACT_ADD      = 3'd0;
    localparam logic [2:0] ACT_REMOVE   = 3'd1;
    localparam logic [2:0] ACT_SELECT   = 3'd2;
    localparam logic [2:0] ACT_ASSIGN   = 3'd3;
    localparam logic [2:0] ACT_COMPLETE = 3'd4;
    localparam logic [2:0] ACT_BUSY     = 3'd5;
    localparam logic [2:0] ACT_HEALTH   = 3'd6;

    localparam logic [1:0] ST_UNKNOWN = 2'd0;
    localparam logic [1:0] ST_ONLINE  = 2'd1;
    localparam logic [1:0] ST_BUSY    = 2'd2;
    localparam logic [1:0] ST_OFFLINE = 2'd3;

    localparam logic [2:0] EV_NONE  = 3'd0;
    localparam logic [2:0] EV_REG   = 3'd1;
    localparam logic [2:0] EV_UNREG = 3'd2;
    localparam logic [2:0] EV_BUSY  = 3'd3;
    localparam logic [2:0] EV_IDLE  = 3'd4;
    localparam logic [2:0] EV_ON    = 3'd5;
    localparam logic [2:0] EV_OFF   = 3'd6;

    localparam logic [1:0] POL_RR   = 2'd0;
    localparam logic [1:0] POL_LL   = 2'd1;
    localparam logic [1:0] POL_RND  = 2'd2;
    localparam logic [1:0] POL_WRND = 2'd3;

    localparam logic [1:0] REG_POLICY = 2'd0;
    localparam logic [1:0] REG_DCAP   = 2'd1;
    localparam logic [1:0] REG_THRESH = 2'd2;
    localparam logic [1:0] REG_SEED   = 2'd3;

    localparam logic [31:0] LFSR_TAPS = 32'h8020_0003;

    typedef struct packed {
        logic [2:0] action;
        logic [3:0] slot;
        logic       healthy;
    } t_req;

    typedef struct packed {
        logic       accepted;
        logic [3:0] chosen_slot;
        logic [2:0] event_code;
    } t_rsp;

    // modulo unit control
    typedef struct packed {
        logic        start;
        logic [31:0] dividend;
        logic [31:0] divisor;
    } t_mod_req;

    typedef struct packed {
        logic        done;
        logic [31:0] rem;
    } t_mod_rsp;

    function automatic logic [31:0] lfsr_next(input logic [31:0] v);
        logic [31:0] n;
        n = v >> 1;
        if (v[0]) n = n ^ LFSR_TAPS;
        if (n == '0) n = 32'd1;
        return n;
    endfunction
endpackage

[hw/rtl/wplb_if.sv]
// Valid/ready channel carrying one word of type T.
// Depends on nothing.
interface wplb_if #(parameter type T = logic) (input logic i_clk);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

[hw/rtl/wplb_mod.sv]
// Bit-serial restoring remainder unit, one bit per cycle.
// Depends on wplb_pkg and worker_pool_load_balancer_assert.svh.
module wplb_mod (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  wplb_pkg::t_mod_req i_req,
    output wplb_pkg::t_mod_rsp o_rsp
);
    import wplb_pkg::*;
    logic [31:0] r_q, r_d;
    logic [31:0] r_rem;
    logic [5:0]  r_cnt;
    logic        r_busy, r_done;
    logic [32:0] shifted, diff;

    always_comb begin
        shifted = {r_rem, r_q[31]};
        diff    = shifted - {1'b0, r_d};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_q    <= i_req.dividend;
                r_d    <= i_req.divisor;
                r_rem  <= '0;
            end else if (r_busy) begin
                r_q <= r_q << 1;
                r_rem <= diff[32] ? shifted[31:0] : diff[31:0];
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'd31) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.rem  = r_rem;

    `include "worker_pool_load_balancer_assert.svh"
    `WPLB_ASSERT_NXT(a_done_pulse, i_clk, i_rst_n, r_done, !r_done)
    `WPLB_ASSERT_IMP(a_rem_lt_div, i_clk, i_rst_n, r_done, r_rem < r_d)
    `WPLB_ASSERT_NXT(a_start_busy, i_clk, i_rst_n, i_req.start, r_busy)
endmodule

[hw/rtl/worker_pool_load_balancer.sv]
// Worker pool load balancer: slot table, action sequencer, APB config.
// Slot actions: S_EXEC applies the request, then S_OUT offers the result.
// Select, least loaded: one scan cycle per slot.
// Other policies: slot scan, a wait on the shared remainder unit, then a
// pick scan. A new request is taken only in S_IDLE, once the result is taken.
// Synchronous active-low reset clears the table and r_rot, presets config.
module worker_pool_load_balancer #(
    parameter int SLOTS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    wplb_if.sink        in_ch,
    wplb_if.source      out_ch,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import wplb_pkg::*;
    localparam int SW = $clog2(SLOTS);
    localparam int CW = $clog2(SLOTS + 1);

    localparam logic [3:0] S_IDLE = 4'd0, S_EXEC = 4'd1, S_SCAN = 4'd2,
        S_MODW = 4'd3, S_PICK = 4'd4, S_WSCAN = 4'd5, S_OUT = 4'd6;

    logic [3:0] r_state;
    logic [SLOTS-1:0] r_valid;
    logic [1:0] r_status [SLOTS];
    logic [7:0] r_act [SLOTS];
    logic [7:0] r_cap [SLOTS];
    logic [7:0] r_fail [SLOTS];
    logic [31:0] r_rot, r_lfsr, r_seed;
    logic [1:0] r_policy;
    logic [7:0] r_dcap, r_thresh;
    t_req r_req;
    t_rsp r_rsp;
    logic [SW-1:0] r_idx;
    logic [CW-1:0] r_n, r_k;
    logic [31:0] r_total, r_cum, r_r;
    logic [SW-1:0] r_best;
    logic r_found;
    logic r_go;
    t_mod_req mreq;
    t_mod_rsp mrsp;

    wplb_mod u_mod (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(mreq), .o_rsp(mrsp));

    logic in_rng;
    logic [SW-1:0] s;
    logic avail;
    logic [7:0] wt;
    logic [15:0] lhs, rhs;
    logic [8:0] inc;

    always_comb begin
        in_rng = ({28'd0, r_req.slot} < 32'(SLOTS));
        s      = SW'(r_req.slot);
        avail  = r_valid[r_idx] && r_status[r_idx] == ST_ONLINE &&
                 r_act[r_idx] < r_cap[r_idx];
        wt     = (r_cap[r_idx] > r_act[r_idx] + 8'd0) ?
                 r_cap[r_idx] - r_act[r_idx] : 8'd1;
        lhs    = r_act[r_idx] * r_cap[r_best];
        rhs    = r_act[r_best] * r_cap[r_idx];
        inc    = {1'b0, r_fail[s]} + 9'd1;
        mreq.start    = r_go;
        mreq.dividend = (r_policy == POL_RR) ? r_rot : r_lfsr;
        mreq.divisor  = (r_policy == POL_WRND) ? r_total : 32'(r_n);
    end

    assign in_ch.ready  = (r_state == S_IDLE);
    assign out_ch.valid = (r_state == S_OUT);
    assign out_ch.data  = r_rsp;
    assign pready       = 1'b1;

    always_comb begin
        unique case (paddr[3:2])
            REG_POLICY: prdata = {30'd0, r_policy};
            REG_DCAP:   prdata = {24'd0, r_dcap};
            REG_THRESH: prdata = {24'd0, r_thresh};
            default:    prdata = r_seed;
        endcase
    end

    logic cfg_wr;
    assign cfg_wr = psel && penable && pwrite;
    logic mod_go;
    assign mod_go = (r_state == S_SCAN) && (r_idx == SW'(SLOTS - 1)) &&
                    (r_n + CW'(avail) != '0) && (r_policy != POL_LL);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_valid  <= '0;
            r_rot    <= '0;
            r_lfsr   <= 32'd1;
            r_seed   <= 32'd1;
            r_policy <= POL_LL;
            r_dcap   <= 8'd4;
            r_thresh <= 8'd3;
            for (int i = 0; i < SLOTS; i++) begin
                r_status[i] <= ST_UNKNOWN;
                r_act[i] <= '0;
                r_cap[i] <= '0;
                r_fail[i] <= '0;
            end
        end else begin
            if (cfg_wr) begin
                unique case (paddr[3:2])
                    REG_POLICY: r_policy <= pwdata[1:0];
                    REG_DCAP:   r_dcap <= pwdata[7:0];
                    REG_THRESH: r_thresh <= pwdata[7:0];
                    default: begin
                        r_seed <= pwdata;
                        r_lfsr <= (pwdata == '0) ? 32'd1 : pwdata;
                    end
                endcase
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_ch.valid) begin
                        r_req <= in_ch.data;
                        r_rsp <= '0;
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    r_state <= S_OUT;
                    r_idx <= '0;
                    r_n <= '0;
                    r_total <= '0;
                    r_found <= 1'b0;
                    case (r_req.action)
                        ACT_ADD: if (in_rng && !r_valid[s]) begin
                            r_valid[s] <= 1'b1;
                            r_status[s] <= ST_UNKNOWN;
                            r_act[s] <= '0;
                            r_cap[s] <= r_dcap;
                            r_fail[s] <= '0;
                            r_rsp.accepted <= 1'b1;
                            r_rsp.event_code <= EV_REG;
                        end
                        ACT_REMOVE: if (in_rng && r_valid[s]) begin
                            r_valid[s] <= 1'b0;
                            r_status[s] <= ST_UNKNOWN;
                            r_act[s] <= '0;
                            r_cap[s] <= '0;
                            r_fail[s] <= '0;
                            r_rsp.accepted <= 1'b1;
                            r_rsp.event_code <= EV_UNREG;
                        end
                        ACT_SELECT: r_state <= S_SCAN;
                        ACT_ASSIGN: if (in_rng && r_valid[s]) begin
                            r_act[s] <= (r_act[s] == 8'hFF) ? 8'hFF : r_act[s] + 8'd1;
                            if (((r_act[s] == 8'hFF) ? 8'hFF : r_act[s] + 8'd1)
                                >= r_cap[s]) begin
                                r_status[s] <= ST_BUSY;
                                r_rsp.event_code <= EV_BUSY;
                            end
                            r_rsp.accepted <= 1'b1;
                        end
                        ACT_COMPLETE: if (in_rng && r_valid[s]) begin
                            r_act[s] <= (r_act[s] == '0) ? '0 : r_act[s] - 8'd1;
                            if (r_status[s] == ST_BUSY &&
                                ((r_act[s] == '0) ? 8'd0 : r_act[s] - 8'd1) < r_cap[s]) begin
                                r_status[s] <= ST_ONLINE;
                                r_rsp.event_code <= EV_IDLE;
                            end
                            r_rsp.accepted <= 1'b1;
                        end
                        ACT_BUSY: if (in_rng && r_valid[s] && r_status[s] == ST_ONLINE) begin
                            r_status[s] <= ST_BUSY;
                            r_act[s] <= r_cap[s];
                            r_rsp.accepted <= 1'b1;
                            r_rsp.event_code <= EV_BUSY;
                        end
                        ACT_HEALTH: if (in_rng && r_valid[s]) begin
                            r_rsp.accepted <= 1'b1;
                            if (r_req.healthy) begin
                                r_fail[s] <= '0;
                                if (r_status[s] == ST_OFFLINE || r_status[s] == ST_UNKNOWN) begin
                                    r_status[s] <= ST_ONLINE;
                                    r_rsp.event_code <= EV_ON;
                                end
                            end else begin
                                r_fail[s] <= inc[8] ? 8'hFF : inc[7:0];
                                if ((inc[8] ? 8'hFF : inc[7:0]) >= r_thresh &&
                                    r_status[s] != ST_OFFLINE) begin
                                    r_status[s] <= ST_OFFLINE;
                                    r_rsp.event_code <= EV_OFF;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
                S_SCAN: begin
                    if (avail) begin
                        r_n <= r_n + CW'(1);
                        r_total <= r_total + 32'(wt);
                        if (!r_found || lhs < rhs) r_best <= r_idx;
                        r_found <= 1'b1;
                    end
                    r_idx <= (r_idx == SW'(SLOTS - 1)) ? '0 : r_idx + SW'(1);
                    if (r_idx == SW'(SLOTS - 1)) begin
                        if (r_n + CW'(avail) == '0) begin
                            r_state <= S_OUT;
                        end else if (r_policy == POL_LL) begin
                            r_rsp.accepted <= 1'b1;
                            r_rsp.chosen_slot <= 4'((avail && (!r_found || lhs < rhs))
                                                    ? r_idx : r_best);
                            r_state <= S_OUT;
                        end else begin
                            if (r_policy == POL_RND || r_policy == POL_WRND)
                                r_lfsr <= lfsr_next(r_lfsr);
                            r_state <= S_MODW;
                        end
                    end
                end
                S_MODW: begin
                    if (mrsp.done) begin
                        r_r <= mrsp.rem;
                        r_k <= '0;
                        r_cum <= '0;
                        r_idx <= '0;
                        if (r_policy == POL_RR) r_rot <= r_rot + 32'd1;
                        r_state <= (r_policy == POL_WRND) ? S_WSCAN : S_PICK;
                    end
                end
                S_PICK, S_WSCAN: begin
                    r_idx <= r_idx + SW'(1);
                    if (avail) begin
                        r_k <= r_k + CW'(1);
                        r_cum <= r_cum + 32'(wt);
                        if ((r_state == S_PICK && 32'(r_k) == r_r) ||
                            (r_state == S_WSCAN && r_r < r_cum + 32'(wt))) begin
                            r_rsp.accepted <= 1'b1;
                            r_rsp.chosen_slot <= 4'(r_idx);
                            r_state <= S_OUT;
                        end
                    end
                end
                S_OUT: if (out_ch.ready) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_go <= 1'b0;
        else r_go <= mod_go;
    end

    `include "worker_pool_load_balancer_assert.svh"
    `WPLB_ASSERT_IMP(a_rdy_idle, i_clk, i_rst_n, in_ch.ready, !out_ch.valid)
    `WPLB_ASSERT_NXT(a_exec_next, i_clk, i_rst_n, r_state == S_EXEC,
        r_state == S_OUT || r_state == S_SCAN)
    `WPLB_ASSERT_IMP(a_modw_pol, i_clk, i_rst_n, r_state == S_MODW, r_policy != POL_LL)
endmodule
